[src/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the step/direction counter reporter: opcodes,
// controller states, frame and checksum constants, checksum unit controls.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

  // default geometry
  localparam int CHANNELS_DEF    = 6;
  localparam int MAX_PAYLOAD_DEF = 30;

  // fixed field widths
  localparam int PIN_W   = 6;
  localparam int AUX_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int RXPOS_W = 5;

  // frame and protocol constants
  localparam logic [7:0]  SYNC_BYTE = 8'hED;
  localparam logic [7:0]  ACK_CMD   = 8'h61;
  localparam logic [15:0] CK_SEED   = 16'hBAD1;
  localparam logic [15:0] CK_MUL    = 16'h6967;
  localparam logic [15:0] CK_ADD    = 16'h1551;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_REPORT = 2'd1,
    OP_RX     = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SWR,
    S_RFETCH,
    S_RWORD,
    S_RLO,
    S_RHI,
    S_RCKLO,
    S_RCKHI,
    S_PKT
  } state_t;

  // checksum unit controls
  typedef struct packed {
    logic init;
    logic add;
    logic step;
  } ck_ctl_t;

  // packet parser result for the current byte
  typedef struct packed {
    logic done;
    logic ack;
  } rx_res_t;

endpackage

`default_nettype wire

[src/scr_ram.sv]
// ----------------------------------------------------------------------------
// scr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/scr_cksum.sv]
// ----------------------------------------------------------------------------
// scr_cksum
// Frame checksum unit: c = ((c + w) * 0x6967 + 0x1551) mod 2^16, with the
// sum registered ahead of the multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_cksum (
  input  wire logic                              clk,
  input  wire scr_pkg::ck_ctl_t                  ctl,
  input  wire logic [scr_pkg::COUNT_W-1:0]       word,
  output logic      [scr_pkg::COUNT_W-1:0]       ck
);

  logic [scr_pkg::COUNT_W-1:0]   sum;
  logic [2*scr_pkg::COUNT_W-1:0] prod;

  // multiply-accumulate step from the registered sum
  assign prod = sum * scr_pkg::CK_MUL;

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      sum <= ck + word;
    end
    if (ctl.init) begin
      ck <= scr_pkg::CK_SEED;
    end else if (ctl.step) begin
      ck <= prod[scr_pkg::COUNT_W-1:0] + scr_pkg::CK_ADD;
    end
  end

endmodule

`default_nettype wire

[src/scr_rx.sv]
// ----------------------------------------------------------------------------
// scr_rx
// Serial packet parser: sync byte, length byte, payload. Flags the byte that
// completes a packet and whether it was the one-byte acknowledge command.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_rx #(
  parameter int MAX_PAYLOAD = scr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic [scr_pkg::BYTE_W-1:0]   rx_byte,
  output scr_pkg::rx_res_t                  res
);

  localparam int PW = scr_pkg::RXPOS_W;

  logic [PW-1:0]              rx_position;
  logic [PW-1:0]              rx_length;
  logic [scr_pkg::BYTE_W-1:0] rx_first;

  logic [PW-1:0]              got;
  logic [PW-1:0]              got1;
  logic [PW-1:0]              need;
  logic [scr_pkg::BYTE_W-1:0] first_eff;
  logic                       complete;

  // payload progress for the current byte
  always_comb begin
    got       = rx_position - PW'(2);
    got1      = got + PW'(1);
    need      = (rx_length != '0) ? rx_length : PW'(1);
    first_eff = (got == '0) ? rx_byte : rx_first;
    complete  = (rx_position > PW'(1)) && (got1 >= need);
    res.done  = en && complete;
    res.ack   = en && complete && (rx_length == PW'(1)) && (first_eff == scr_pkg::ACK_CMD);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_position <= '0;
      rx_length   <= '0;
      rx_first    <= '0;
    end else if (en) begin
      if (rx_position == '0) begin
        if (rx_byte == scr_pkg::SYNC_BYTE) begin
          rx_position <= PW'(1);
        end
      end else if (rx_position == PW'(1)) begin
        if (rx_byte > scr_pkg::BYTE_W'(MAX_PAYLOAD)) begin
          rx_position <= '0;
        end else begin
          rx_length   <= rx_byte[PW-1:0];
          rx_position <= PW'(2);
        end
      end else begin
        rx_first <= first_eff;
        if (complete) begin
          rx_position <= '0;
        end else begin
          rx_position <= got1 + PW'(2);
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/step_dir_counter_reporter.sv]
// ----------------------------------------------------------------------------
// step_dir_counter_reporter
// Step/direction position counters with a serial report frame and a small
// packet receiver.
//
// One input channel (in_valid/in_ready) carries an opcode and its operands;
// one output channel (out_valid/out_ready) carries frame bytes and packet
// results, one beat each. Input is taken one item at a time, only in idle.
// Pin sample: one counter RAM read-modify-write per channel, through states
//   SRD then SWR, with no output beat.
// Report request: 2*CHANNELS+6 beats. Each 16-bit word takes a RAM read, a
//   checksum add and a registered multiply, through states RFETCH, RWORD,
//   RLO and RHI; the count RAM port and the checksum multiply set the pace
//   of the words, and a stalled receiver holds it in RLO or RHI.
// Received byte: parsed in the cycle of acceptance; a completed packet gives
//   one beat, loaded from state PKT once the output register is free.
// The output register holds a beat until taken; the controller waits while
// it is full, so a stalled receiver simply stretches the frame.
// Reset clears the controller, parser, sticky bits and per-channel valid
// bits; a counter never written reads as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module step_dir_counter_reporter #(
  parameter int CHANNELS    = scr_pkg::CHANNELS_DEF,
  parameter int MAX_PAYLOAD = scr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [scr_pkg::PIN_W-1:0]     step_pins,
  input  wire logic [scr_pkg::PIN_W-1:0]     dir_pins,
  input  wire logic [scr_pkg::AUX_W-1:0]     aux_pins,
  input  wire logic [scr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [scr_pkg::BYTE_W-1:0]    tx_byte,
  output logic                               last,
  output logic                               packet_done,
  output logic                               packet_ack
);

  localparam int CW     = scr_pkg::COUNT_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NWORDS = CHANNELS + 2;
  localparam int WI_W   = $clog2(NWORDS);
  localparam logic [7:0] LEN_BYTE = 8'(2 * CHANNELS + 4);

  scr_pkg::state_t  state, state_next;
  scr_pkg::ck_ctl_t ck_ctl;
  scr_pkg::rx_res_t rx_res;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [7:0]          out_byte_n;
  logic                out_last_n;
  logic                out_done_n;
  logic                out_ack_n;

  logic [CHANNELS-1:0] step_ext;
  logic [CHANNELS-1:0] dir_ext;
  logic [CHANNELS-1:0] prev_step;
  logic [CHANNELS-1:0] rise;
  logic [CHANNELS-1:0] dir;
  logic [CHANNELS-1:0] vld;
  logic                rd_vld;
  logic [1:0]          sticky;
  logic [1:0]          snap;
  logic                pkt_ack;
  logic [CH_W-1:0]     idx;
  logic [WI_W-1:0]     widx;
  logic [WI_W-1:0]     wm1;
  logic [CW-1:0]       word;
  logic [CW-1:0]       wsel;
  logic [CW-1:0]       ram_val;
  logic [CW-1:0]       ck;

  logic                ram_we;
  logic [CH_W-1:0]     ram_waddr;
  logic [CW-1:0]       ram_wdata;
  logic                ram_re;
  logic [CH_W-1:0]     ram_raddr;
  logic [CW-1:0]       ram_rdata;

  assign in_ready = (state == scr_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wm1      = widx - WI_W'(1);
  assign ram_val  = rd_vld ? ram_rdata : '0;

  // pins widened to the channel count, bits past the pin field read as zero
  always_comb begin
    for (int n = 0; n < CHANNELS; n++) begin
      step_ext[n] = (n < scr_pkg::PIN_W) ? step_pins[n % scr_pkg::PIN_W] : 1'b0;
      dir_ext[n]  = (n < scr_pkg::PIN_W) ? dir_pins[n % scr_pkg::PIN_W] : 1'b0;
    end
  end

  // current frame word
  always_comb begin
    if (widx == '0) begin
      wsel = {LEN_BYTE, scr_pkg::SYNC_BYTE};
    end else if (widx == WI_W'(NWORDS - 1)) begin
      wsel = {12'b0, snap, 2'b0};
    end else begin
      wsel = ram_val;
    end
  end

  // controller next state and strobes
  always_comb begin
    state_next  = state;
    ck_ctl      = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = dir[idx] ? ram_val + CW'(1) : ram_val - CW'(1);
    ram_re      = 1'b0;
    ram_raddr   = idx;
    out_load    = 1'b0;
    out_byte_n  = '0;
    out_last_n  = 1'b0;
    out_done_n  = 1'b0;
    out_ack_n   = 1'b0;
    case (state)
      scr_pkg::S_IDLE: begin
        if (accept) begin
          case (scr_pkg::op_t'(op))
            scr_pkg::OP_SAMPLE: state_next = scr_pkg::S_SRD;
            scr_pkg::OP_REPORT: begin
              ck_ctl.init = 1'b1;
              state_next  = scr_pkg::S_RFETCH;
            end
            scr_pkg::OP_RX: begin
              if (rx_res.done) begin
                state_next = scr_pkg::S_PKT;
              end
            end
            default: state_next = scr_pkg::S_IDLE;
          endcase
        end
      end
      scr_pkg::S_SRD: begin
        ram_re     = 1'b1;
        state_next = scr_pkg::S_SWR;
      end
      scr_pkg::S_SWR: begin
        ram_we = rise[idx];
        if (idx == CH_W'(CHANNELS - 1)) begin
          state_next = scr_pkg::S_IDLE;
        end else begin
          state_next = scr_pkg::S_SRD;
        end
      end
      scr_pkg::S_RFETCH: begin
        ram_re     = (widx != '0) && (widx != WI_W'(NWORDS - 1));
        ram_raddr  = wm1[CH_W-1:0];
        state_next = scr_pkg::S_RWORD;
      end
      scr_pkg::S_RWORD: begin
        ck_ctl.add = 1'b1;
        state_next = scr_pkg::S_RLO;
      end
      scr_pkg::S_RLO: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_byte_n  = word[7:0];
          ck_ctl.step = 1'b1;
          state_next  = scr_pkg::S_RHI;
        end
      end
      scr_pkg::S_RHI: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_n = word[15:8];
          if (widx == WI_W'(NWORDS - 1)) begin
            state_next = scr_pkg::S_RCKLO;
          end else begin
            state_next = scr_pkg::S_RFETCH;
          end
        end
      end
      scr_pkg::S_RCKLO: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_n = ck[7:0];
          state_next = scr_pkg::S_RCKHI;
        end
      end
      scr_pkg::S_RCKHI: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_n = ck[15:8];
          out_last_n = 1'b1;
          state_next = scr_pkg::S_IDLE;
        end
      end
      scr_pkg::S_PKT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_n = 1'b1;
          out_done_n = 1'b1;
          out_ack_n  = pkt_ack;
          state_next = scr_pkg::S_IDLE;
        end
      end
      default: state_next = scr_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state: edges, sticky bits, counter valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_step <= '0;
      sticky    <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && scr_pkg::op_t'(op) == scr_pkg::OP_SAMPLE) begin
        prev_step <= step_ext;
        sticky    <= sticky | aux_pins;
      end else if (accept && scr_pkg::op_t'(op) == scr_pkg::OP_REPORT) begin
        sticky <= '0;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rise    <= step_ext & ~prev_step;
      dir     <= dir_ext;
      snap    <= sticky;
      pkt_ack <= rx_res.ack;
      idx     <= '0;
      widx    <= '0;
    end
    if (ram_re) begin
      rd_vld <= vld[ram_raddr];
    end
    if (state == scr_pkg::S_SWR && idx != CH_W'(CHANNELS - 1)) begin
      idx <= idx + CH_W'(1);
    end
    if (state == scr_pkg::S_RWORD) begin
      word <= wsel;
    end
    if (state == scr_pkg::S_RHI && out_free && widx != WI_W'(NWORDS - 1)) begin
      widx <= widx + WI_W'(1);
    end
    if (out_load) begin
      tx_byte     <= out_byte_n;
      last        <= out_last_n;
      packet_done <= out_done_n;
      packet_ack  <= out_ack_n;
    end
  end

  // position counts
  scr_ram #(
    .WIDTH (CW),
    .DEPTH (CHANNELS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // frame checksum
  scr_cksum u_cksum (
    .clk  (clk),
    .ctl  (ck_ctl),
    .word (wsel),
    .ck   (ck)
  );

  // packet parser
  scr_rx #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_rx (
    .clk     (clk),
    .rst     (rst),
    .en      (accept && scr_pkg::op_t'(op) == scr_pkg::OP_RX),
    .rx_byte (rx_byte),
    .res     (rx_res)
  );

endmodule

`default_nettype wire
